// File: hdl/rdq_pkg.sv
`default_nettype none
package rdq_pkg;

  // Request codes carried in the action field.
  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_INSERT = 2'd2;
  localparam logic [1:0] ACT_ERASE  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Field widths on the stream channels.
  localparam int ACT_W  = 2;
  localparam int POS_W  = 11;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 11;

  // Field placement inside tdata, lowest bit first.
  localparam int IN_ACT_LSB   = 0;
  localparam int IN_POS_LSB   = IN_ACT_LSB + ACT_W;
  localparam int IN_VAL_LSB   = IN_POS_LSB + POS_W;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_VAL_LSB  = 0;
  localparam int OUT_STAT_LSB = OUT_VAL_LSB + VAL_W;
  localparam int OUT_CNT_LSB  = OUT_STAT_LSB + STAT_W;
  localparam int OUT_TDATA_W  = 48;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture an accepted request
    logic decide;     // check the request and set up its work
    logic capture;    // take the store's read data as the result value
    logic step;       // one element move
    logic final_wr;   // write the inserted value
    logic erase_upd;  // shrink the deque after an erase
    logic emit;       // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             err;
    logic             busy;
    logic             out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: hdl/rdq_ram.sv
`default_nettype none
module rdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: hdl/rdq_dp.sv
`default_nettype none
module rdq_dp #(
  parameter int CAPACITY     = 1024,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rdq_pkg::cmd_t                  cmd,
  output rdq_pkg::stat_t                 stat,
  input  logic [rdq_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rdq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import rdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int EW = ELEMENT_BITS;

  // Request held for the duration of its work.
  logic [ACT_W-1:0] act_r;
  logic [POS_W-1:0] pos_r;
  logic [EW-1:0]    wv_r;
  logic [EW-1:0]    rv_r;
  logic [STAT_W-1:0] status_r;
  logic             left_r;

  // Deque state.
  logic [AW-1:0]    head_r;
  logic [CW-1:0]    count_r;

  // Move sequencer.
  logic [CW-1:0]    dst_r;
  logic [CW-1:0]    mleft_r;
  logic             asc_r;
  logic             pend_r;
  logic [CW-1:0]    pend_dst_r;

  // Output register.
  logic             out_valid_r;
  logic [VAL_W-1:0] out_rv_r;
  logic [STAT_W-1:0] out_st_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic [PW-1:0]     pos_w;
  logic [PW-1:0]     cnt_w;
  logic [CW-1:0]     pos_c;
  logic [CW-1:0]     room_ins;
  logic [CW-1:0]     room_er;
  logic              ins_left;
  logic              er_left;
  logic [STAT_W-1:0] status_c;
  logic [AW-1:0]     head_dec;
  logic [AW-1:0]     head_inc;
  logic [CW-1:0]     src_idx;
  logic [CW-1:0]     rd_idx;
  logic [CW-1:0]     wr_idx;
  logic              wr_en;
  logic [EW-1:0]     wr_data;
  logic [EW-1:0]     rd_data;

  // Logical index to store address; the sum stays below twice the capacity.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(idx);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return AW'(s);
  endfunction

  assign pos_w    = PW'(pos_r);
  assign cnt_w    = PW'(count_r);
  assign pos_c    = CW'(pos_w);
  assign room_ins = count_r - pos_c;
  assign room_er  = count_r - CW'(1) - pos_c;
  assign ins_left = pos_c < room_ins;
  assign er_left  = pos_c < room_er;
  assign head_dec = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(CAPACITY - 1)) ? '0 : head_r + AW'(1);
  assign src_idx  = asc_r ? dst_r + CW'(1) : dst_r - CW'(1);

  always_comb begin
    status_c = STAT_OK;
    unique case (act_r) inside
      ACT_INSERT: begin
        if (pos_w > cnt_w) begin
          status_c = STAT_RANGE;
        end else if (count_r == CW'(CAPACITY)) begin
          status_c = STAT_FULL;
        end
      end
      ACT_READ, ACT_WRITE, ACT_ERASE: begin
        if (pos_w >= cnt_w) begin
          status_c = STAT_RANGE;
        end
      end
      default: status_c = STAT_RANGE;
    endcase
  end

  // Store port selection.
  always_comb begin
    rd_idx  = pos_c;
    wr_idx  = pos_c;
    wr_en   = 1'b0;
    wr_data = wv_r;
    if (cmd.decide && status_c == STAT_OK && act_r == ACT_WRITE) begin
      wr_en = 1'b1;
    end
    if (cmd.step) begin
      if (mleft_r != '0) begin
        rd_idx = src_idx;
      end
      if (pend_r) begin
        wr_en   = 1'b1;
        wr_idx  = pend_dst_r;
        wr_data = rd_data;
      end
    end
    if (cmd.final_wr) begin
      wr_en = 1'b1;
    end
  end

  rdq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (phys(head_r, wr_idx)),
    .wr_data (wr_data),
    .rd_addr (phys(head_r, rd_idx)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      mleft_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        act_r <= in_tdata[IN_ACT_LSB +: ACT_W];
        pos_r <= in_tdata[IN_POS_LSB +: POS_W];
        wv_r  <= EW'(in_tdata[IN_VAL_LSB +: VAL_W]);
        rv_r  <= '0;
      end

      if (cmd.decide) begin
        status_r <= status_c;
        if (status_c == STAT_OK) begin
          if (act_r == ACT_INSERT) begin
            count_r <= count_r + CW'(1);
            left_r  <= ins_left;
            if (ins_left) begin
              head_r  <= head_dec;
              dst_r   <= '0;
              asc_r   <= 1'b1;
              mleft_r <= pos_c;
            end else begin
              dst_r   <= count_r;
              asc_r   <= 1'b0;
              mleft_r <= room_ins;
            end
          end else if (act_r == ACT_ERASE) begin
            left_r <= er_left;
            dst_r  <= pos_c;
            if (er_left) begin
              asc_r   <= 1'b0;
              mleft_r <= pos_c;
            end else begin
              asc_r   <= 1'b1;
              mleft_r <= room_er;
            end
          end
        end
      end

      if (cmd.capture) begin
        rv_r <= rd_data;
      end

      if (cmd.step) begin
        if (mleft_r != '0) begin
          pend_r     <= 1'b1;
          pend_dst_r <= dst_r;
          dst_r      <= src_idx;
          mleft_r    <= mleft_r - CW'(1);
        end else begin
          pend_r <= 1'b0;
        end
      end

      if (cmd.erase_upd) begin
        count_r <= count_r - CW'(1);
        if (count_r == CW'(1)) begin
          head_r <= '0;
        end else if (left_r) begin
          head_r <= head_inc;
        end
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        out_rv_r    <= VAL_W'(rv_r);
        out_st_r    <= status_r;
        out_cnt_r   <= CNT_W'(count_r);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.act      = act_r;
  assign stat.err      = status_c != STAT_OK;
  assign stat.busy     = (mleft_r != '0) || pend_r;
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    (OUT_TDATA_W - OUT_CNT_LSB - CNT_W)'(0),
    out_cnt_r,
    out_st_r,
    out_rv_r
  };

endmodule
`default_nettype wire

// File: hdl/rdq_ctrl.sv
`default_nettype none
module rdq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  rdq_pkg::stat_t stat,
  output rdq_pkg::cmd_t  cmd
);

  import rdq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_FINAL  = 3'd4;
  localparam logic [2:0] S_ERUPD  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.err) begin
          state_nxt = S_DONE;
        end else begin
          unique case (stat.act) inside
            ACT_READ, ACT_ERASE: state_nxt = S_RDWAIT;
            ACT_INSERT:          state_nxt = S_MOVE;
            default:             state_nxt = S_DONE;
          endcase
        end
      end
      S_RDWAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = (stat.act == ACT_ERASE) ? S_MOVE : S_DONE;
      end
      S_MOVE: begin
        cmd.step = 1'b1;
        if (!stat.busy) begin
          state_nxt = (stat.act == ACT_INSERT) ? S_FINAL : S_ERUPD;
        end
      end
      S_FINAL: begin
        cmd.final_wr = 1'b1;
        state_nxt    = S_DONE;
      end
      S_ERUPD: begin
        cmd.erase_upd = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ring_deque_positional_insert_erase_top.sv
// Channel   Direction  Contents
// in_*      slave      one request: action, position, write value
// out_*     master     one result per request: read value, status, count after
//
// A read is checked and then read from the store before its result is offered;
// an overwrite or a rejected request is offered straight after the check. An
// insert checks, moves elements and writes the new value; an erase checks, reads,
// moves elements and shrinks the deque. At most half the capacity is moved, and
// one read and one write port pace the moves. Reset clears the head position and
// element count; the store is not cleared. A stalled output holds its result, and
// the next request transfers in after the last result enters the output register.
`default_nettype none
module ring_deque_positional_insert_erase_top #(
  parameter int CAPACITY     = 1024,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0 up: action[1:0], position[12:2], write_value[44:13].
  input  logic [rdq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0 up: read_value[31:0], status[33:32], count_after[44:34].
  output logic [rdq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import rdq_pkg::*;

  // Command and status between the sequencer and the datapath.
  cmd_t  cmd;
  stat_t stat;

  // The controller steps each request through check, store accesses and the
  // element moves, then hands the result to the output register.
  rdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the ring store, head, count, move sequencer and the
  // output register that decouples the result channel from the request side.
  rdq_dp #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the ring deque with positional insert and erase.
//
// Every request that transfers into the block is applied at once to a
// behavioural copy of the deque, kept here as a plain queue of elements in
// logical order. The block's head position is not visible from outside, so
// only the logical contents matter to the prediction. Each predicted result
// is queued, and a checker process compares every result transfer with the
// oldest one, field by field.
module tb_top;
  import rdq_pkg::*;

  localparam int DEPTH = 1024;

  // Result fields, listed in the order the block packs them from bit 0 up.
  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } deque_result_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Behavioural copy of the deque, front element at index 0.
  logic [VAL_W-1:0] deque_model[$];
  deque_result_t    expected_results[$];

  int  burst_left;
  int  error_count;
  int  results_checked;
  int  peak_fill;
  int  action_tally[4];
  int  status_tally[4];
  // Bumped by a test to ask the receiver for one long hold-off.
  int  hold_req_count = 0;

  ring_deque_positional_insert_erase_top #(
    .CAPACITY    (DEPTH),
    .ELEMENT_BITS(VAL_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one request to the copy of the deque and returns its result.
  // Index checks come before the full check, as in the block.
  function automatic deque_result_t apply_request(logic [ACT_W-1:0] act, int pos,
                                                  logic [VAL_W-1:0] val);
    deque_result_t res;
    int            held;
    res  = '0;
    held = deque_model.size();
    case (act)
      ACT_READ, ACT_WRITE: begin
        if (pos >= held) begin
          res.status = STAT_RANGE;
        end else if (act == ACT_READ) begin
          res.value = deque_model[pos];
        end else begin
          deque_model[pos] = val;
        end
      end
      ACT_INSERT: begin
        if (pos > held) begin
          res.status = STAT_RANGE;
        end else if (held >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          deque_model.insert(pos, val);
        end
      end
      default: begin
        if (pos >= held) begin
          res.status = STAT_RANGE;
        end else begin
          res.value = deque_model[pos];
          deque_model.delete(pos);
        end
      end
    endcase
    res.count = CNT_W'(deque_model.size());
    return res;
  endfunction

  // Offers one request and waits for its transfer. The sender works in
  // bursts; between bursts it may drop tvalid. Within a burst tvalid stays
  // high from one transfer to the next.
  task automatic send_request(input logic [ACT_W-1:0] act, input int pos,
                              input logic [VAL_W-1:0] val);
    logic [IN_TDATA_W-1:0] word;
    deque_result_t         res;
    int                    gap;
    word = '0;
    word[IN_ACT_LSB +: ACT_W] = act;
    word[IN_POS_LSB +: POS_W] = POS_W'(pos);
    word[IN_VAL_LSB +: VAL_W] = val;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = apply_request(act, pos, val);
    expected_results.push_back(res);
    action_tally[act]++;
    status_tally[res.status]++;
    if (deque_model.size() > peak_fill) peak_fill = deque_model.size();
  endtask

  // Receiver: stretches of steady readiness, random stalls and a sparse
  // periodic pattern, plus a long hold-off whenever a test asks for one.
  initial begin
    int seg_left;
    int mode;
    int phase;
    int hold_left;
    int hold_seen;
    seg_left  = 0;
    mode      = 0;
    phase     = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_req_count != hold_seen) begin
        hold_seen = hold_req_count;
        hold_left = 600;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        mode     = $urandom_range(0, 2);
      end
      seg_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= (phase % 4 == 0);
        endcase
      end
    end
  end

  // Checker: every result transfer is matched against the oldest prediction.
  initial begin
    deque_result_t want;
    deque_result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.value  = out_tdata[OUT_VAL_LSB +: VAL_W];
        got.status = out_tdata[OUT_STAT_LSB +: STAT_W];
        got.count  = out_tdata[OUT_CNT_LSB +: CNT_W];
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding: %h", out_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got.value !== want.value) begin
            $error("read_value: expected %h, got %h", want.value, got.value);
            error_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
          end
          if (got.count !== want.count) begin
            $error("count_after: expected %0d, got %0d", want.count, got.count);
            error_count++;
          end
        end
      end
    end
  end

  // Starting from empty: every request rejected on an empty deque, growth
  // from both ends with the head wrapping below zero, the tie cases of the
  // side choice, reads and overwrites of both ends, and erasing down to
  // empty so that the head returns to zero.
  task automatic test_empty_and_ends();
    send_request(ACT_READ,   0,    32'h1111_1111);
    send_request(ACT_WRITE,  0,    32'h2222_2222);
    send_request(ACT_ERASE,  0,    32'h3333_3333);
    send_request(ACT_INSERT, 1,    32'h4444_4444);
    send_request(ACT_READ,   DEPTH, 32'h0);
    send_request(ACT_INSERT, 0,    32'hFFFF_FFFF);
    // A front insert into one element moves left and wraps the head.
    send_request(ACT_INSERT, 0,    32'h0000_0000);
    send_request(ACT_INSERT, 2,    32'hA5A5_A5A5);
    send_request(ACT_INSERT, 1,    32'h5A5A_5A5A);
    // Index 2 of four is a tie, so the back part moves.
    send_request(ACT_INSERT, 2,    32'h1234_5678);
    for (int i = 0; i < 5; i++) send_request(ACT_READ, i, $urandom());
    send_request(ACT_WRITE,  4,    32'hDEAD_BEEF);
    send_request(ACT_WRITE,  0,    32'h0000_0001);
    // Index 2 of five is the erase tie, again a move to the right.
    send_request(ACT_ERASE,  2,    $urandom());
    send_request(ACT_ERASE,  0,    $urandom());
    send_request(ACT_ERASE,  2,    $urandom());
    send_request(ACT_ERASE,  1,    $urandom());
    send_request(ACT_ERASE,  0,    $urandom());
    send_request(ACT_INSERT, 0,    32'h8000_0001);
    send_request(ACT_READ,   0,    $urandom());
  endtask

  // Grows the deque to capacity. Most inserts go to either end, which costs
  // no element moves; the rest land anywhere and can force long moves. A few
  // reads, overwrites and erases, some out of range, are mixed in.
  task automatic test_fill_to_capacity();
    int roll;
    int pick;
    int held;
    int pos;
    while (deque_model.size() < DEPTH) begin
      roll = $urandom_range(0, 99);
      held = deque_model.size();
      if (roll < 92) begin
        pick = $urandom_range(0, 9);
        pos  = (pick < 4) ? 0 : (pick < 8) ? held : $urandom_range(0, held);
        send_request(ACT_INSERT, pos, $urandom());
      end else if (roll < 95) begin
        send_request(ACT_READ, $urandom_range(0, DEPTH), $urandom());
      end else if (roll < 98) begin
        send_request(ACT_WRITE, $urandom_range(0, DEPTH), $urandom());
      end else begin
        send_request(ACT_ERASE, $urandom_range(0, held), $urandom());
      end
    end
  endtask

  // At capacity: the highest index, inserts that must be refused, and
  // erases that are allowed while full, each followed by a refilling insert, on both sides of the middle.
  task automatic test_full_store();
    send_request(ACT_READ,   DEPTH,     $urandom());
    send_request(ACT_WRITE,  DEPTH - 1, 32'hFFFF_FFFF);
    send_request(ACT_READ,   DEPTH - 1, $urandom());
    send_request(ACT_INSERT, DEPTH,     $urandom());
    send_request(ACT_INSERT, 0,         $urandom());
    send_request(ACT_ERASE,  DEPTH / 2 - 1, $urandom());
    send_request(ACT_INSERT, DEPTH / 2, $urandom());
    send_request(ACT_ERASE,  0,         $urandom());
    send_request(ACT_INSERT, 0,         $urandom());
    send_request(ACT_READ,   0,         $urandom());
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the output register fills and the block stops taking input.
  task automatic test_output_backpressure();
    hold_req_count++;
    for (int i = 0; i < 12; i++) begin
      send_request(($urandom_range(0, 1) == 0) ? ACT_READ : ACT_WRITE,
                   $urandom_range(0, DEPTH), $urandom());
    end
  endtask

  // Random positional traffic around the full mark.
  task automatic test_random_near_full();
    int held;
    logic [ACT_W-1:0] act;
    for (int i = 0; i < 30; i++) begin
      held = deque_model.size();
      act  = ACT_W'($urandom_range(0, 3));
      if (act == ACT_INSERT) begin
        send_request(act, $urandom_range(0, held), $urandom());
      end else if (act == ACT_ERASE) begin
        send_request(act, $urandom_range(0, (held > 0) ? held - 1 : 0), $urandom());
      end else begin
        send_request(act, $urandom_range(0, DEPTH), $urandom());
      end
    end
  endtask

  initial begin
    burst_left      = 0;
    error_count     = 0;
    results_checked = 0;
    peak_fill       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_ends();
    test_fill_to_capacity();
    test_full_store();
    test_output_backpressure();
    test_random_near_full();

    // Let every outstanding result come out, then keep watching in case the
    // block sends anything unasked.
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d reads, %0d overwrites, %0d inserts and %0d erases; %0d results checked.",
             action_tally[ACT_READ], action_tally[ACT_WRITE], action_tally[ACT_INSERT],
             action_tally[ACT_ERASE], results_checked);
    $display("Index errors %0d, refused inserts %0d, largest fill %0d of %0d elements.",
             status_tally[STAT_RANGE], status_tally[STAT_FULL], peak_fill, DEPTH);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog. About 1200 requests, each moving at worst half the capacity,
  // plus sender gaps and receiver stalls, finish well within this limit,
  // which leaves a wide margin.
  initial begin
    #48_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
